// ===== rtl/cpts_pkg.sv =====
// Shared types and constants for the counter priority task scheduler.
// Used by cpts_ctrl, cpts_dp and the top level. No dependencies.

package cpts_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int REQ_W  = 16;
    localparam int SLOT_W = 6;
    localparam int ST_W   = 2;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;
    localparam int PRI_W  = 8;
    localparam int CTR_W  = 16;
    localparam int DEP_W  = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_YIELD   = 3'd1;
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd2;
    localparam logic [OP_W-1:0] OP_PDIS    = 3'd3;
    localparam logic [OP_W-1:0] OP_PEN     = 3'd4;
    localparam logic [OP_W-1:0] OP_SETRUN  = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
    localparam logic [ST_W-1:0] ST_NORUN   = 2'd2;
    localparam logic [ST_W-1:0] ST_BADSLOT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MIN_PRI  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_PRI  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_TS   = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_INIT_PRI = 2'd3;

    // Register reset values
    localparam logic [CFG_DW-1:0] MIN_PRI_RST  = 8'd1;
    localparam logic [CFG_DW-1:0] MAX_PRI_RST  = 8'd15;
    localparam logic [CFG_DW-1:0] MIN_TS_RST   = 8'd1;
    localparam logic [CFG_DW-1:0] INIT_PRI_RST = 8'd1;

    // Recompute rounds before giving up with no runnable pick
    localparam int RECOMPUTE_ROUNDS = 32;
    localparam int RND_W = $clog2(RECOMPUTE_ROUNDS + 1);

    localparam logic signed [CTR_W-1:0] CTR_MIN = 16'sh8000;

    // One slot record as stored in the slot table
    typedef struct packed {
        logic        [PRI_W-1:0] pri;
        logic signed [CTR_W-1:0] ctr;
        logic        [DEP_W-1:0] dep;
    } cpts_ent_t;

    localparam int ENT_W = $bits(cpts_ent_t);

    // Commands from controller to datapath
    typedef struct packed {
        logic            accept;
        logic            rd_cur;
        logic            exec;
        logic            pass_start;
        logic            pass_recomp;
        logic            pass_step;
        logic            sw_rd_old;
        logic            sw_wr_old;
        logic            sw_rd_new;
        logic            sw_wr_new;
        logic            st_load;
        logic [ST_W-1:0] st_code;
        logic            out_load;
    } cpts_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic sched_need;
        logic pass_done;
        logic found;
        logic any_run;
        logic best_is_cur;
        logic out_free;
    } cpts_sts_t;

endpackage

// ===== rtl/cpts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.

module cpts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/cpts_ctrl.sv =====
// Scheduler controller: sequences operation, pick passes, recompute rounds
// and task switch. Depends on cpts_pkg.

module cpts_ctrl
    import cpts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  cpts_sts_t sts,
    output cpts_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RDCUR  = 11'b000_0000_0010,
        S_EXEC   = 11'b000_0000_0100,
        S_PICK   = 11'b000_0000_1000,
        S_RECOMP = 11'b000_0001_0000,
        S_NORUN  = 11'b000_0010_0000,
        S_SWRDO  = 11'b000_0100_0000,
        S_SWWRO  = 11'b000_1000_0000,
        S_SWRDN  = 11'b001_0000_0000,
        S_SWWRN  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } cpts_state_t;

    cpts_state_t            state_reg, state_next;
    logic [RND_W-1:0]       round_reg, round_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RDCUR;
                end
            end
            S_RDCUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.sched_need)
                begin
                    cmd.pass_start = 1'b1;
                    state_next     = S_PICK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PICK:
            begin
                if (!sts.pass_done)
                begin
                    cmd.pass_step = 1'b1;
                end
                else if (sts.found)
                begin
                    state_next = sts.best_is_cur ? S_DONE : S_SWRDO;
                end
                else if (!sts.any_run)
                begin
                    // nothing runnable: one recompute pass, then report
                    cmd.pass_start  = 1'b1;
                    cmd.pass_recomp = 1'b1;
                    state_next      = S_NORUN;
                end
                else
                begin
                    cmd.pass_start  = 1'b1;
                    cmd.pass_recomp = 1'b1;
                    round_next      = RND_W'(1);
                    state_next      = S_RECOMP;
                end
            end
            S_RECOMP:
            begin
                if (!sts.pass_done)
                begin
                    cmd.pass_step = 1'b1;
                end
                else if (sts.found)
                begin
                    state_next = sts.best_is_cur ? S_DONE : S_SWRDO;
                end
                else if (round_reg == RND_W'(RECOMPUTE_ROUNDS))
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NORUN;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.pass_start  = 1'b1;
                    cmd.pass_recomp = 1'b1;
                    round_next      = round_reg + RND_W'(1);
                end
            end
            S_NORUN:
            begin
                if (!sts.pass_done)
                begin
                    cmd.pass_step = 1'b1;
                end
                else
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NORUN;
                    state_next  = S_DONE;
                end
            end
            S_SWRDO:
            begin
                cmd.sw_rd_old = 1'b1;
                state_next    = S_SWWRO;
            end
            S_SWWRO:
            begin
                cmd.sw_wr_old = 1'b1;
                state_next    = S_SWRDN;
            end
            S_SWRDN:
            begin
                cmd.sw_rd_new = 1'b1;
                state_next    = S_SWWRN;
            end
            S_SWWRN:
            begin
                cmd.sw_wr_new = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

endmodule

// ===== rtl/cpts_dp.sv =====
// Scheduler datapath: slot table, runnable bits, task count, config
// registers, pick/recompute pass and result register.
// Depends on cpts_pkg and cpts_ram.

module cpts_dp
    import cpts_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cpts_cmd_t           cmd,
    output cpts_sts_t           sts,
    input  logic [OP_W-1:0]     operation,
    input  logic signed [REQ_W-1:0] priority_req,
    input  logic [SLOT_W-1:0]   slot,
    input  logic                runnable,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ST_W-1:0]     status,
    output logic [SLOT_W-1:0]   current_task,
    output logic                switched,
    output logic [SLOT_W-1:0]   new_slot
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int TC_W  = $clog2(SLOT_COUNT + 1);

    // Latched item
    logic [OP_W-1:0]         op_reg;
    logic signed [REQ_W-1:0] req_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    run_reg;

    // Config
    logic [PRI_W-1:0] min_pri_reg, max_pri_reg, min_ts_reg;

    // Scheduler state
    logic [SLOT_COUNT-1:0] runnable_reg;
    logic [TC_W-1:0]       tc_reg;
    logic [IDX_W-1:0]      cur_reg;
    logic                  slot0_wr_reg;
    logic                  rd_init_reg;

    // Pass state
    logic [TC_W-1:0]         issue_reg;
    logic                    pend_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic                    recomp_reg;
    logic                    best_vld_reg;
    logic [IDX_W-1:0]        best_reg;
    logic signed [CTR_W-1:0] top_reg;

    // Item result
    logic [ST_W-1:0]   st_reg;
    logic              sw_reg;
    logic [IDX_W-1:0]  new_reg;

    // Output register
    logic              out_valid_reg;
    logic [ST_W-1:0]   out_st_reg;
    logic [SLOT_W-1:0] out_cur_reg;
    logic              out_sw_reg;
    logic [SLOT_W-1:0] out_new_reg;

    // Table port
    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [ENT_W-1:0]  wr_data, rd_data;

    cpts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Slot 0 reads as the init task until first written
    cpts_ent_t ent;
    always_comb
    begin
        if (rd_init_reg)
        begin
            ent.pri = INIT_PRI_RST;
            ent.ctr = '0;
            ent.dep = '0;
        end
        else
        begin
            ent = cpts_ent_t'(rd_data);
        end
    end

    // Entry arithmetic
    logic signed [CTR_W-1:0] ctr_dec;
    logic [DEP_W-1:0]        dep_inc, dep_dec;
    logic                    tick_sched;

    assign ctr_dec    = (ent.ctr == CTR_MIN) ? ent.ctr : ent.ctr - 16'sd1;
    assign dep_inc    = (ent.dep == '1) ? ent.dep : ent.dep + DEP_W'(1);
    assign dep_dec    = (ent.dep == '0) ? ent.dep : ent.dep - DEP_W'(1);
    assign tick_sched = (ctr_dec <= 16'sd0) && (ent.dep == '0);

    // Timeslice recompute: min(max(min_ts, c/2 + prio), 2*prio)
    logic signed [CTR_W-1:0] half;
    logic signed [17:0]      nc_sum, nc_lo, nc_hi, nc_floor, nc_clip;
    logic signed [CTR_W-1:0] nc;
    logic signed [CTR_W-1:0] cand;

    assign half     = ent.ctr >>> 1;
    assign nc_sum   = 18'(half) + signed'({10'd0, ent.pri});
    assign nc_lo    = signed'({10'd0, min_ts_reg});
    assign nc_hi    = signed'({9'd0, ent.pri, 1'b0});
    assign nc_floor = (nc_sum < nc_lo) ? nc_lo : nc_sum;
    assign nc_clip  = (nc_floor > nc_hi) ? nc_hi : nc_floor;
    assign nc       = nc_clip[CTR_W-1:0];
    assign cand     = recomp_reg ? nc : ent.ctr;

    // Create priority clamp, lower bound checked first
    logic signed [REQ_W:0] req_x, min_x, max_x;
    logic [PRI_W-1:0]      pri_new;
    logic                  full;
    logic                  setrun_ok;

    assign req_x = 17'(req_reg);
    assign min_x = signed'({9'd0, min_pri_reg});
    assign max_x = signed'({9'd0, max_pri_reg});
    always_comb
    begin
        if (req_x < min_x)
        begin
            pri_new = min_pri_reg;
        end
        else if (req_x > max_x)
        begin
            pri_new = max_pri_reg;
        end
        else
        begin
            pri_new = req_x[PRI_W-1:0];
        end
    end

    assign full      = (tc_reg == TC_W'(SLOT_COUNT));
    assign setrun_ok = (32'(slot_reg) < 32'(tc_reg));

    // Table read and write selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = ent;
        if (cmd.rd_cur || cmd.sw_rd_old)
        begin
            rd_en = 1'b1;
        end
        if (cmd.sw_rd_new)
        begin
            rd_en   = 1'b1;
            rd_addr = best_reg;
        end
        if (cmd.pass_step && (issue_reg != tc_reg))
        begin
            rd_en   = 1'b1;
            rd_addr = issue_reg[IDX_W-1:0];
        end
        if (cmd.exec)
        begin
            case (op_reg)
                OP_TICK:
                begin
                    wr_en   = 1'b1;
                    wr_data = {ent.pri, (tick_sched ? 16'sd0 : ctr_dec), ent.dep};
                end
                OP_YIELD:
                begin
                    wr_en   = (ent.dep == '0);
                    wr_data = {ent.pri, 16'sd0, ent.dep};
                end
                OP_CREATE:
                begin
                    wr_en   = !full;
                    wr_addr = tc_reg[IDX_W-1:0];
                    wr_data = {pri_new, {8'd0, pri_new}, DEP_W'(1)};
                end
                OP_PDIS:
                begin
                    wr_en   = 1'b1;
                    wr_data = {ent.pri, ent.ctr, dep_inc};
                end
                OP_PEN:
                begin
                    wr_en   = 1'b1;
                    wr_data = {ent.pri, ent.ctr, dep_dec};
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        if (cmd.pass_step && pend_reg && recomp_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg;
            wr_data = {ent.pri, nc, ent.dep};
        end
        if (cmd.sw_wr_old)
        begin
            wr_en   = 1'b1;
            wr_data = {ent.pri, ent.ctr, dep_inc};
        end
        if (cmd.sw_wr_new)
        begin
            wr_en   = 1'b1;
            wr_addr = best_reg;
            wr_data = {ent.pri, ent.ctr, dep_dec};
        end
    end

    // Status to controller
    assign sts.sched_need  = (op_reg == OP_TICK)  ? tick_sched :
                             (op_reg == OP_YIELD) ? (ent.dep == '0) : 1'b0;
    assign sts.pass_done   = (issue_reg == tc_reg) && !pend_reg;
    assign sts.found       = best_vld_reg;
    assign sts.any_run     = |runnable_reg;
    assign sts.best_is_cur = (best_reg == cur_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    // Payload latch, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= operation;
            req_reg  <= priority_req;
            slot_reg <= slot;
            run_reg  <= runnable;
        end
    end

    // Config registers; a write to the init priority index is ignored, slot 0 uses INIT_PRI_RST
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pri_reg <= MIN_PRI_RST;
            max_pri_reg <= MAX_PRI_RST;
            min_ts_reg  <= MIN_TS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_PRI:  min_pri_reg <= cfg_data;
                CFG_MAX_PRI:  max_pri_reg <= cfg_data;
                CFG_MIN_TS:   min_ts_reg  <= cfg_data;
                CFG_INIT_PRI: min_ts_reg  <= min_ts_reg;
                default:      min_ts_reg  <= min_ts_reg;
            endcase
        end
    end

    // Scheduler state, pass state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runnable_reg <= SLOT_COUNT'(1);
            tc_reg       <= TC_W'(1);
            cur_reg      <= '0;
            slot0_wr_reg <= 1'b0;
            rd_init_reg  <= 1'b0;
            issue_reg    <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            recomp_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            best_reg     <= '0;
            top_reg      <= '0;
            st_reg       <= ST_OK;
            sw_reg       <= 1'b0;
            new_reg      <= '0;
        end
        else
        begin
            rd_init_reg <= rd_en && (rd_addr == '0) && !slot0_wr_reg;
            if (wr_en && (wr_addr == '0))
            begin
                slot0_wr_reg <= 1'b1;
            end

            if (cmd.accept)
            begin
                st_reg  <= ST_OK;
                sw_reg  <= 1'b0;
                new_reg <= '0;
            end

            // operation on current slot or table
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (full)
                        begin
                            st_reg <= ST_FULL;
                        end
                        else
                        begin
                            runnable_reg[tc_reg[IDX_W-1:0]] <= 1'b1;
                            new_reg <= tc_reg[IDX_W-1:0];
                            tc_reg  <= tc_reg + TC_W'(1);
                        end
                    end
                    OP_SETRUN:
                    begin
                        if (setrun_ok)
                        begin
                            runnable_reg[slot_reg[IDX_W-1:0]] <= run_reg;
                        end
                        else
                        begin
                            st_reg <= ST_BADSLOT;
                        end
                    end
                    default:
                    begin
                        st_reg <= st_reg;
                    end
                endcase
            end

            if (cmd.st_load)
            begin
                st_reg <= cmd.st_code;
            end

            // pick / recompute pass, one slot a cycle
            if (cmd.pass_start)
            begin
                issue_reg    <= '0;
                pend_reg     <= 1'b0;
                recomp_reg   <= cmd.pass_recomp;
                best_vld_reg <= 1'b0;
                top_reg      <= '0;
            end
            else if (cmd.pass_step)
            begin
                pend_reg     <= (issue_reg != tc_reg);
                pend_idx_reg <= issue_reg[IDX_W-1:0];
                if (issue_reg != tc_reg)
                begin
                    issue_reg <= issue_reg + TC_W'(1);
                end
                if (pend_reg && runnable_reg[pend_idx_reg] && (cand > top_reg))
                begin
                    top_reg      <= cand;
                    best_reg     <= pend_idx_reg;
                    best_vld_reg <= 1'b1;
                end
            end

            if (cmd.sw_wr_new)
            begin
                cur_reg <= best_reg;
                sw_reg  <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_st_reg  <= st_reg;
            out_cur_reg <= SLOT_W'(cur_reg);
            out_sw_reg  <= sw_reg;
            out_new_reg <= SLOT_W'(new_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_st_reg;
    assign current_task = out_cur_reg;
    assign switched     = out_sw_reg;
    assign new_slot     = out_new_reg;

endmodule

// ===== rtl/counter_priority_task_scheduler.sv =====
// Operations that do not reschedule pass through read current, execute and
// done; a schedule adds table passes over the tasks, up to 33, and a task
// switch reads and writes the old, then the new slot. One item at a time, the
// next after the result is loaded; the single table read port sets the pass.
// Reset: slot 0 valid and runnable as init task, no clearing pass needed.
// Depends on cpts_pkg, cpts_ctrl, cpts_dp (and cpts_ram).

module counter_priority_task_scheduler
    import cpts_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         operation,
    input  logic signed [REQ_W-1:0] priority_req,
    input  logic [SLOT_W-1:0]       slot,
    input  logic                    runnable,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IW-1:0]       cfg_index,
    input  logic [CFG_DW-1:0]       cfg_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ST_W-1:0]         status,
    output logic [SLOT_W-1:0]       current_task,
    output logic                    switched,
    output logic [SLOT_W-1:0]       new_slot
);

    cpts_cmd_t cmd;
    cpts_sts_t sts;

    cpts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpts_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .priority_req (priority_req),
        .slot         (slot),
        .runnable     (runnable),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .current_task (current_task),
        .switched     (switched),
        .new_slot     (new_slot)
    );

`ifndef SYNTHESIS
    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a switch only comes with a good schedule
    a_sw_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && switched) |-> (status == ST_OK))
        else $error("switch reported with bad status");

    // a created slot never comes with a switch or an error
    a_create: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (new_slot != '0)) |-> (status == ST_OK && !switched))
        else $error("create result inconsistent");
`endif

endmodule
